// ----- rtl/owrwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrwm_pkg: shared constants for the overwrite ring window mean block
// Command codes, field widths and the default store depth.
// ----------------------------------------------------------------------------
package owrwm_pkg;

    // Default window capacity in samples
    localparam int MAX_DEPTH_DEF = 256;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int NDEPTH_W = 16;
    localparam int CMD_W    = 2;
    localparam int MEAN_W   = 36;
    localparam int IN_W     = 48;  // sample + new_depth, already whole bytes

    // Command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Mean reported for an empty window (-1.0 in tenths)
    localparam logic signed [MEAN_W-1:0] EMPTY_MEAN = -36'sd10;

endpackage

// ----- rtl/owrwm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrwm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module owrwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/overwrite_ring_window_mean.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_window_mean: ring window of samples with a running mean
// Insert / resize / clear commands; each item returns count and mean*10.
// ----------------------------------------------------------------------------
// One item in, one result out. Samples live in a single-port-read sample RAM;
// a running sum is kept in a register, so an insert costs one RAM read and
// one write. The mean (sum*10/count, truncated toward zero) comes from a
// restoring divider that retires one quotient bit per cycle over 44 bits. The
// next item is taken only once the result has gone to the output register and
// the sequencer is back in idle. An item that leaves the window empty skips
// the divider (a clear always does). A valid resize first copies the kept
// samples out to a scratch RAM and back, compacted, at one sample per cycle
// each way. A new item is taken while the previous result still waits in the
// output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module overwrite_ring_window_mean #(
    parameter int  MAX_DEPTH = owrwm_pkg::MAX_DEPTH_DEF,
    localparam int CW        = $clog2(MAX_DEPTH + 1),
    localparam int PAY_W     = owrwm_pkg::MEAN_W + CW + 1,
    localparam int OUT_W     = ((PAY_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input items
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [31:0] sample, [47:32] new_depth
    input  logic [owrwm_pkg::IN_W-1:0] i_s_axis_tdata,
    // [1:0] cmd
    input  logic [owrwm_pkg::CMD_W-1:0] i_s_axis_tuser,
    // Result items
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // [35:0] mean_tenths, [35+CW:36] fill_count, [36+CW] ok, rest zero
    output logic [OUT_W-1:0]           o_m_axis_tdata
);

    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SW    = owrwm_pkg::SAMPLE_W;
    localparam int SUM_W = SW + CW;
    localparam int DVD_W = SUM_W + 3;
    localparam int IW    = $clog2(DVD_W);
    localparam int MW    = owrwm_pkg::MEAN_W;

    // State codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_CPA  = 3'd2;
    localparam logic [2:0] S_CPB  = 3'd3;
    localparam logic [2:0] S_ABS  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]              r_state;
    logic [SW-1:0]           r_sample;
    logic [CW-1:0]           r_nd;
    logic [CW-1:0]           r_keep;
    logic                    r_ok;
    logic [AW-1:0]           r_pos;
    logic [CW-1:0]           r_held;
    logic [AW-1:0]           r_oldest;
    logic [CW-1:0]           r_depth;
    logic signed [SUM_W-1:0] r_sum;
    logic [CW-1:0]           r_cnt;
    logic [AW-1:0]           r_rslot;
    logic                    r_wv;
    logic [AW-1:0]           r_widx;
    logic [DVD_W-1:0]        r_dvd;
    logic [CW-1:0]           r_rem;
    logic                    r_neg;
    logic [IW-1:0]           r_iter;
    logic                    r_ovalid;
    logic [PAY_W-1:0]        r_odata;

    // Input fields
    logic [owrwm_pkg::CMD_W-1:0]    in_cmd;
    logic [SW-1:0]                  in_sample;
    logic [owrwm_pkg::NDEPTH_W-1:0] in_nd;
    logic [CW-1:0]                  nd_cw;
    logic                           nd_bad;
    logic                           accept;

    assign in_cmd    = i_s_axis_tuser;
    assign in_sample = i_s_axis_tdata[SW-1:0];
    assign in_nd     = i_s_axis_tdata[SW + owrwm_pkg::NDEPTH_W - 1:SW];
    assign nd_cw     = CW'(in_nd);
    assign nd_bad    = (in_nd == '0) || (17'(in_nd) > 17'(MAX_DEPTH));
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    // Ring slot arithmetic: wrap at the current depth
    logic [CW:0]   ins_raw, ins_wrap;
    logic [CW:0]   old_raw, rs_raw;
    logic [AW-1:0] ins_pos, old_next, rs_next;

    always_comb begin
        ins_raw  = (CW+1)'(r_oldest) + (CW+1)'(r_held);
        ins_wrap = (ins_raw >= {1'b0, r_depth}) ? ins_raw - {1'b0, r_depth} : ins_raw;
        ins_pos  = ins_wrap[AW-1:0];
        old_raw  = (CW+1)'(r_oldest) + (CW+1)'(1);
        old_next = (old_raw >= {1'b0, r_depth}) ? '0 : old_raw[AW-1:0];
        rs_raw   = (CW+1)'(r_rslot) + (CW+1)'(1);
        rs_next  = (rs_raw >= {1'b0, r_depth}) ? '0 : rs_raw[AW-1:0];
    end

    // Sample store and compaction scratch RAM
    logic          st_we, tp_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata, tp_rdata;

    assign st_we    = (r_state == S_INS) || ((r_state == S_CPB) && r_wv);
    assign st_waddr = (r_state == S_INS) ? r_pos : r_widx;
    assign st_wdata = (r_state == S_INS) ? r_sample : tp_rdata;
    assign st_raddr = (r_state == S_CPA) ? r_rslot : ins_pos;
    assign tp_we    = (r_state == S_CPA) && r_wv;

    owrwm_ram #(.WIDTH(SW), .DEPTH(MAX_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    owrwm_ram #(.WIDTH(SW), .DEPTH(MAX_DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (tp_we),
        .i_waddr (r_widx),
        .i_wdata (st_rdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (tp_rdata)
    );

    // Datapath helpers
    logic signed [SUM_W-1:0] st_ext, smp_ext;
    logic [SUM_W-1:0]        sum_mag;
    logic [CW:0]             trial, trial_diff;
    logic                    trial_ge;
    logic [MW-1:0]           quot;
    logic [MW-1:0]           mean;
    logic                    out_free;

    always_comb begin
        st_ext     = SUM_W'(signed'(st_rdata));
        smp_ext    = SUM_W'(signed'(r_sample));
        sum_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        trial      = {r_rem, r_dvd[DVD_W-1]};
        trial_diff = trial - {1'b0, r_held};
        trial_ge   = (trial >= {1'b0, r_held});
        quot       = r_dvd[MW-1:0];
        if (r_held == '0) begin
            mean = owrwm_pkg::EMPTY_MEAN;
        end else if (r_neg) begin
            mean = -quot;
        end else begin
            mean = quot;
        end
    end

    assign out_free        = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = OUT_W'(r_odata);

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_oldest <= '0;
            r_depth  <= CW'(MAX_DEPTH);
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_wv     <= 1'b0;
        end else begin
            // Result taken; S_OUT reloads it in the same cycle
            if (r_ovalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= in_sample;
                        r_pos    <= ins_pos;
                        case (in_cmd)
                            owrwm_pkg::CMD_INSERT: begin
                                r_ok    <= 1'b1;
                                r_state <= S_INS;
                            end
                            owrwm_pkg::CMD_RESIZE: begin
                                if (nd_bad) begin
                                    r_ok    <= 1'b0;
                                    r_state <= S_ABS;
                                end else begin
                                    r_ok    <= 1'b1;
                                    r_nd    <= nd_cw;
                                    r_keep  <= (r_held < nd_cw) ? r_held : nd_cw;
                                    r_cnt   <= '0;
                                    r_wv    <= 1'b0;
                                    r_rslot <= r_oldest;
                                    r_sum   <= '0;
                                    r_state <= S_CPA;
                                end
                            end
                            owrwm_pkg::CMD_CLEAR: begin
                                r_ok     <= 1'b1;
                                r_held   <= '0;
                                r_oldest <= '0;
                                r_sum    <= '0;
                                r_state  <= S_ABS;
                            end
                            default: begin
                                r_ok    <= 1'b1;
                                r_state <= S_ABS;
                            end
                        endcase
                    end
                end
                // Store the sample; drop the overwritten one from the sum
                S_INS: begin
                    if (r_held == r_depth) begin
                        r_sum    <= r_sum + smp_ext - st_ext;
                        r_oldest <= old_next;
                    end else begin
                        r_sum  <= r_sum + smp_ext;
                        r_held <= r_held + CW'(1);
                    end
                    r_state <= S_ABS;
                end
                // Copy kept samples, oldest first, into scratch and re-sum
                S_CPA: begin
                    if (r_cnt < r_keep) begin
                        r_rslot <= rs_next;
                        r_cnt   <= r_cnt + CW'(1);
                        r_widx  <= r_cnt[AW-1:0];
                        r_wv    <= 1'b1;
                    end else begin
                        r_wv <= 1'b0;
                    end
                    if (r_wv) begin
                        r_sum <= r_sum + st_ext;
                    end
                    if ((r_cnt >= r_keep) && !r_wv) begin
                        r_cnt   <= '0;
                        r_state <= S_CPB;
                    end
                end
                // Copy scratch back to the store from index zero
                S_CPB: begin
                    if (r_cnt < r_keep) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_widx <= r_cnt[AW-1:0];
                        r_wv   <= 1'b1;
                    end else begin
                        r_wv <= 1'b0;
                    end
                    if ((r_cnt >= r_keep) && !r_wv) begin
                        r_oldest <= '0;
                        r_held   <= r_keep;
                        r_depth  <= r_nd;
                        r_state  <= S_ABS;
                    end
                end
                // Magnitude and sign of the sum
                S_ABS: begin
                    r_neg <= r_sum[SUM_W-1];
                    r_dvd <= DVD_W'(sum_mag);
                    r_state <= (r_held == '0) ? S_OUT : S_MUL;
                end
                // Times ten
                S_MUL: begin
                    r_dvd   <= (r_dvd << 3) + (r_dvd << 1);
                    r_rem   <= '0;
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                // Restoring division by the count, one bit a cycle
                S_DIV: begin
                    r_rem  <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
                    r_dvd  <= {r_dvd[DVD_W-2:0], trial_ge};
                    r_iter <= r_iter + IW'(1);
                    if (r_iter == IW'(DVD_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                // Hand the result to the output register
                S_OUT: begin
                    if (out_free) begin
                        r_odata  <= {r_ok, r_held, mean};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Window bookkeeping stays consistent
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_held <= r_depth)
        else $error("held count above window depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) && (r_depth <= CW'(MAX_DEPTH)))
        else $error("window depth out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> ((CW+1)'(r_oldest) < {1'b0, r_depth}))
        else $error("oldest index outside window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_held == '0)) |-> (r_sum == '0))
        else $error("running sum nonzero with empty window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_cmd == owrwm_pkg::CMD_RESIZE) && nd_bad)
        |=> ($stable(r_held) && $stable(r_depth) && $stable(r_oldest)))
        else $error("rejected resize changed the window");

endmodule
